>>> rtl/core/assert_macros.svh
// Assertion macros for the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never hold at a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

>>> rtl/core/fdc_pkg.sv
// Types, constants and the CRC-32 lookup table for the frame deframer.
package fdc_pkg;

	// Frame layout
	localparam int unsigned HEADER_BYTES     = 12;
	localparam int unsigned HDR_MAGIC_LAST   = 3;
	localparam int unsigned HDR_VERSION_LAST = 7;
	localparam int unsigned CRC_BYTES        = 4;
	localparam int unsigned OUT_LEN_BITS     = 24;

	// CRC-32, reflected form
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Configuration register indexes
	localparam logic [1:0] CFG_MAGIC   = 2'd0;
	localparam logic [1:0] CFG_VERSION = 2'd1;
	localparam logic [1:0] CFG_MAX_LEN = 2'd2;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	// Frame status codes
	localparam logic [2:0] ST_GOOD        = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_LEN_OVER    = 3'd3;
	localparam logic [2:0] ST_CRC_BAD     = 3'd4;

	// Deframer phase
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_TRAILER
	} phase_t;

	// Configuration registers as seen by the deframer
	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] version;
		logic [23:0] max_len;
	} cfg_t;

	typedef logic [31:0] crc_table_t [256];

	// Byte-wise CRC table, built at elaboration
	function automatic crc_table_t crc_table_build();
		crc_table_t  t;
		logic [31:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 32'(i);
			for (int k = 0; k < 8; k++) begin
				c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
			end
			t[i] = c;
		end
		return t;
	endfunction

	localparam crc_table_t CRC_TABLE = crc_table_build();

endpackage

>>> rtl/core/fdc_crc_step.sv
// One-byte CRC-32 update through the lookup table.
module fdc_crc_step (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data,
	output logic [31:0] crc_out
);
	import fdc_pkg::*;

	logic [7:0] idx;

	// Table step: shift out one byte, fold in the table entry
	assign idx     = crc_in[7:0] ^ data;
	assign crc_out = (crc_in >> 8) ^ CRC_TABLE[idx];

endmodule

>>> rtl/core/fdc_deframer.sv
// Frame parser state, CRC check and result register.
module fdc_deframer #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fdc_pkg::cfg_t       cfg,
	input  logic                step_valid,
	input  logic [7:0]          step_byte,
	output logic                step_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                result_kind,
	output logic [7:0]          payload_byte,
	output logic [2:0]          frame_status,
	output logic [23:0]         frame_payload_length
);
	import fdc_pkg::*;

	// Frame state
	phase_t                 phase_q, phase_d;
	logic [LENGTH_BITS-1:0] cnt_q, cnt_d;
	logic [31:0]            hdr_q, hdr_d;
	logic                   magic_ok_q, magic_ok_d;
	logic                   version_ok_q, version_ok_d;
	logic [LENGTH_BITS-1:0] len_q, len_d;
	logic [31:0]            crc_q, crc_d;
	logic [31:0]            rx_crc_q, rx_crc_d;

	// Result register
	logic        res_valid_q;
	logic        res_kind_q;
	logic [7:0]  res_byte_q;
	logic [2:0]  res_status_q;
	logic [23:0] res_len_q;

	// Result of the current byte
	logic        emit;
	logic        emit_kind;
	logic [7:0]  emit_byte;
	logic [2:0]  emit_status;
	logic [23:0] emit_len;

	logic        fire;
	logic [31:0] crc_next;
	logic [31:0] hdr_shift;
	logic [31:0] rx_shift;
	logic [3:0]  hdr_pos;
	logic        len_over;
	logic        last_payload;
	logic        last_trailer;

	fdc_crc_step u_crc (
		.crc_in  (crc_q),
		.data    (step_byte),
		.crc_out (crc_next)
	);

	// Byte is taken when the result register is free or drains this cycle
	assign step_ready = !res_valid_q || out_ready;
	assign fire       = step_valid && step_ready;

	assign hdr_shift    = {step_byte, hdr_q[31:8]};
	assign rx_shift     = {step_byte, rx_crc_q[31:8]};
	assign hdr_pos      = cnt_q[3:0];
	assign len_over     = (hdr_shift > {8'd0, cfg.max_len}) ||
		((hdr_shift >> LENGTH_BITS) != 32'd0);
	assign last_payload = (cnt_q == len_q - LENGTH_BITS'(1));
	assign last_trailer = (cnt_q[1:0] == 2'(CRC_BYTES - 1));

	// Next state
	always_comb begin
		phase_d      = phase_q;
		cnt_d        = cnt_q;
		hdr_d        = hdr_q;
		magic_ok_d   = magic_ok_q;
		version_ok_d = version_ok_q;
		len_d        = len_q;
		crc_d        = crc_q;
		rx_crc_d     = rx_crc_q;
		case (phase_q)
			PH_HEADER: begin
				crc_d = crc_next;
				hdr_d = hdr_shift;
				cnt_d = cnt_q + LENGTH_BITS'(1);
				if (hdr_pos == 4'(HDR_MAGIC_LAST)) begin
					magic_ok_d = (hdr_shift == cfg.magic);
				end
				if (hdr_pos == 4'(HDR_VERSION_LAST)) begin
					version_ok_d = (hdr_shift == cfg.version);
				end
				if (hdr_pos == 4'(HEADER_BYTES - 1)) begin
					len_d   = hdr_shift[LENGTH_BITS-1:0];
					cnt_d   = '0;
					phase_d = (hdr_shift == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				crc_d = crc_next;
				cnt_d = cnt_q + LENGTH_BITS'(1);
				if (last_payload) begin
					cnt_d   = '0;
					phase_d = PH_TRAILER;
				end
			end
			PH_TRAILER: begin
				rx_crc_d = rx_shift;
				cnt_d    = cnt_q + LENGTH_BITS'(1);
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
		// Frame end or oversize length: back to a fresh frame
		if (emit && emit_kind == KIND_STATUS) begin
			phase_d      = PH_HEADER;
			cnt_d        = '0;
			hdr_d        = '0;
			magic_ok_d   = 1'b0;
			version_ok_d = 1'b0;
			len_d        = '0;
			crc_d        = CRC_INIT;
			rx_crc_d     = '0;
		end
	end

	// Result of this byte
	always_comb begin
		emit        = 1'b0;
		emit_kind   = KIND_PAYLOAD;
		emit_byte   = 8'd0;
		emit_status = ST_GOOD;
		emit_len    = OUT_LEN_BITS'(len_q);
		case (phase_q)
			PH_HEADER: begin
				if (hdr_pos == 4'(HEADER_BYTES - 1) && len_over) begin
					emit        = 1'b1;
					emit_kind   = KIND_STATUS;
					emit_status = ST_LEN_OVER;
					emit_len    = (hdr_shift > 32'h00FF_FFFF) ? 24'hFF_FFFF :
						hdr_shift[23:0];
				end
			end
			PH_PAYLOAD: begin
				emit      = 1'b1;
				emit_byte = step_byte;
			end
			PH_TRAILER: begin
				if (last_trailer) begin
					emit      = 1'b1;
					emit_kind = KIND_STATUS;
					if (!magic_ok_q) begin
						emit_status = ST_BAD_MAGIC;
					end else if (!version_ok_q) begin
						emit_status = ST_BAD_VERSION;
					end else if ((crc_q ^ CRC_INIT) != rx_shift) begin
						emit_status = ST_CRC_BAD;
					end else begin
						emit_status = ST_GOOD;
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			cnt_q        <= '0;
			hdr_q        <= '0;
			magic_ok_q   <= 1'b0;
			version_ok_q <= 1'b0;
			len_q        <= '0;
			crc_q        <= CRC_INIT;
			rx_crc_q     <= '0;
		end else if (fire) begin
			phase_q      <= phase_d;
			cnt_q        <= cnt_d;
			hdr_q        <= hdr_d;
			magic_ok_q   <= magic_ok_d;
			version_ok_q <= version_ok_d;
			len_q        <= len_d;
			crc_q        <= crc_d;
			rx_crc_q     <= rx_crc_d;
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step_ready) begin
			res_valid_q <= fire && emit;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_kind_q   <= emit_kind;
			res_byte_q   <= emit_byte;
			res_status_q <= emit_status;
			res_len_q    <= emit_len;
		end
	end

	assign out_valid            = res_valid_q;
	assign result_kind          = res_kind_q;
	assign payload_byte         = res_byte_q;
	assign frame_status         = res_status_q;
	assign frame_payload_length = res_len_q;

endmodule

>>> rtl/core/frame_deframer_crc32_check.sv
// Top level of the length-prefixed frame deframer with CRC-32 check.
// Sustains one byte per clock while the output side is ready: a byte is registered
// at the input, parsed from that register (one CRC table lookup plus counters and
// compares) and its result, if any, is held in the output register, which offers it
// to the output side. Each payload byte gives one payload result; the last CRC byte,
// or an oversize length at the end of the header, gives one status result. Input
// and output stall only on the output side's ready. There is no clearing pass after
// reset. Write the configuration registers only while no frame is in flight; a write
// mid-frame applies to compares not yet made.
module frame_deframer_crc32_check #(
	parameter int unsigned LENGTH_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [2:0]  frame_status,
	output logic [23:0] frame_payload_length
);
	import fdc_pkg::*;

	`include "assert_macros.svh"

	cfg_t       cfg_q;
	logic       byte_valid_s1;
	logic [7:0] byte_s1;
	logic       step_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic   <= 32'd0;
			cfg_q.version <= 32'd1;
			cfg_q.max_len <= 24'd65536;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAGIC:   cfg_q.magic   <= cfg_data;
				CFG_VERSION: cfg_q.version <= cfg_data;
				CFG_MAX_LEN: cfg_q.max_len <= cfg_data[23:0];
				default:     cfg_q         <= cfg_q;
			endcase
		end
	end

	// Input register: refills as soon as its byte moves on
	assign in_ready = !byte_valid_s1 || step_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			byte_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

	fdc_deframer #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_deframer (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg_q),
		.step_valid           (byte_valid_s1),
		.step_byte            (byte_s1),
		.step_ready           (step_ready),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.result_kind          (result_kind),
		.payload_byte         (payload_byte),
		.frame_status         (frame_status),
		.frame_payload_length (frame_payload_length)
	);

	// A held input byte is not lost or overwritten while the parser stalls
	`ASSERT_CLK(a_s1_hold, byte_valid_s1 && !step_ready |=> byte_valid_s1 && $stable(byte_s1), "input byte dropped during stall")
	// Status codes stay within the defined set
	`ASSERT_NEVER(a_status_range, out_valid && frame_status > ST_CRC_BAD, "undefined frame status")
	// Payload results carry no status, status results carry no byte
	`ASSERT_CLK(a_kind_fields, out_valid |-> (result_kind == KIND_PAYLOAD && frame_status == ST_GOOD) || (result_kind == KIND_STATUS && payload_byte == 8'd0), "result fields inconsistent with kind")

endmodule

>>> verif/tb_frame_deframer_crc32_check.sv
// Self-checking testbench for the byte-stream frame deframer with CRC-32 check.
`timescale 1ns / 1ps

module tb_frame_deframer_crc32_check;
	import fdc_pkg::*;

	localparam int unsigned LEN_FIELD_BITS = 24;
	localparam logic [31:0] LEN_FIELD_MAX  = (32'd1 << LEN_FIELD_BITS) - 32'd1;
	localparam logic [23:0] LEN_SHOWN_MAX  = 24'hFF_FFFF;
	localparam logic [1:0]  CFG_UNUSED     = 2'd3;
	localparam int unsigned DRAIN_CYCLES   = 6;
	localparam int unsigned WHOLE_FRAME    = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [2:0]  status;
		logic [23:0] len;
	} frame_result_t;

	// DUT ports
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_MAGIC;
	logic [31:0] cfg_data = 32'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [2:0]  frame_status;
	logic [23:0] frame_payload_length;

	// Deframer state as the checker sees it
	logic [31:0] cfg_magic;
	logic [31:0] cfg_version;
	logic [23:0] cfg_max_len;
	int unsigned frame_pos;
	logic [31:0] hdr_word;
	logic        magic_ok;
	logic        version_ok;
	logic [23:0] cur_body_len;
	logic [31:0] frame_crc;
	logic [31:0] crc_rx;

	frame_result_t expected_results[$];

	// Traffic shaping and bookkeeping
	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned rx_hold_req = 0;
	int unsigned mismatches = 0;
	int unsigned bytes_offered = 0;
	int unsigned bytes_taken = 0;
	int unsigned payloads_seen = 0;
	int unsigned input_stalls = 0;
	int unsigned status_count[8];

	frame_deframer_crc32_check dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.in_byte              (in_byte),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.result_kind          (result_kind),
		.payload_byte         (payload_byte),
		.frame_status         (frame_status),
		.frame_payload_length (frame_payload_length)
	);

	// 100 MHz clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// One byte through the reflected CRC-32 shift register
	function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic void frame_restart();
		frame_pos    = 0;
		hdr_word     = 32'd0;
		magic_ok     = 1'b0;
		version_ok   = 1'b0;
		cur_body_len = 24'd0;
		frame_crc    = CRC_INIT;
		crc_rx       = 32'd0;
	endfunction

	function automatic void expect_result(logic kind, logic [7:0] data, logic [2:0] status,
			logic [23:0] len);
		frame_result_t r;
		r.kind   = kind;
		r.data   = data;
		r.status = status;
		r.len    = len;
		expected_results.insert(expected_results.size(), r);
	endfunction

	// Advance the deframer state by one accepted byte and queue what it yields
	function automatic void predict_byte(logic [7:0] b);
		logic [2:0] st;
		if (frame_pos < HEADER_BYTES) begin
			frame_crc = crc32_update(frame_crc, b);
			hdr_word  = {b, hdr_word[31:8]};
			if (frame_pos == HDR_MAGIC_LAST) begin
				magic_ok = (hdr_word == cfg_magic);
			end else if (frame_pos == HDR_VERSION_LAST) begin
				version_ok = (hdr_word == cfg_version);
			end else if (frame_pos == HEADER_BYTES - 1) begin
				// oversize length ends the frame right away, regardless of magic/version
				if (hdr_word > {8'd0, cfg_max_len} || hdr_word > LEN_FIELD_MAX) begin
					expect_result(KIND_STATUS, 8'd0, ST_LEN_OVER,
						(hdr_word > {8'd0, LEN_SHOWN_MAX}) ? LEN_SHOWN_MAX : hdr_word[23:0]);
					frame_restart();
					return;
				end
				cur_body_len = hdr_word[23:0];
			end
			frame_pos++;
		end else if (frame_pos - HEADER_BYTES < 32'(cur_body_len)) begin
			frame_crc = crc32_update(frame_crc, b);
			frame_pos++;
			expect_result(KIND_PAYLOAD, b, ST_GOOD, cur_body_len);
		end else begin
			crc_rx = {b, crc_rx[31:8]};
			frame_pos++;
			if (frame_pos - HEADER_BYTES - 32'(cur_body_len) >= CRC_BYTES) begin
				if (!magic_ok)
					st = ST_BAD_MAGIC;
				else if (!version_ok)
					st = ST_BAD_VERSION;
				else if ((frame_crc ^ CRC_INIT) != crc_rx)
					st = ST_CRC_BAD;
				else
					st = ST_GOOD;
				expect_result(KIND_STATUS, 8'd0, st, cur_body_len);
				frame_restart();
			end
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("[%0t] mismatch: %s got %0h expected %0h", $time, what, got, want);
	endtask

	task automatic check_result();
		frame_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with nothing pending, kind", 32'(result_kind), 0);
			return;
		end
		want = expected_results.pop_front();
		if (result_kind !== want.kind)
			report_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
		if (payload_byte !== want.data)
			report_mismatch("payload_byte", 32'(payload_byte), 32'(want.data));
		if (frame_status !== want.status)
			report_mismatch("frame_status", 32'(frame_status), 32'(want.status));
		if (frame_payload_length !== want.len)
			report_mismatch("frame_payload_length", 32'(frame_payload_length),
				32'(want.len));
		if (want.kind == KIND_STATUS)
			status_count[want.status]++;
		else
			payloads_seen++;
	endtask

	// Predict on accepted input requests, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predict_byte(in_byte);
				bytes_taken++;
			end
			if (in_valid && !in_ready)
				input_stalls++;
			if (out_valid && out_ready)
				check_result();
		end
	end

	// Result side ready: random stalls, plus long hold-offs on request
	initial begin : rx_ready_gen
		int unsigned n;
		forever begin
			@(posedge clk);
			if (rx_hold_req != 0) begin
				n = rx_hold_req;
				rx_hold_req = 0;
				out_ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
				out_ready <= 1'b0;
				repeat (gap_len() - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Offer one byte, optionally after an idle gap, and wait until it is taken
	task automatic send_byte(input logic [7:0] b);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		bytes_offered++;
		do @(posedge clk); while (!in_ready);
	endtask

	// Build a frame (fill < 0 gives random payload) and send its first cut_at bytes
	task automatic send_frame(input logic [31:0] magic, input logic [31:0] version,
			input logic [31:0] len_field, input int unsigned body_n, input int fill,
			input bit bad_crc, input int unsigned cut_at);
		logic [7:0]  frame_bytes[$];
		logic [31:0] crc;
		for (int i = 0; i < 4; i++)
			frame_bytes.insert(frame_bytes.size(), magic[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			frame_bytes.insert(frame_bytes.size(), version[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			frame_bytes.insert(frame_bytes.size(), len_field[8*i +: 8]);
		for (int unsigned i = 0; i < body_n; i++)
			frame_bytes.insert(frame_bytes.size(),
				(fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
		crc = CRC_INIT;
		foreach (frame_bytes[i])
			crc = crc32_update(crc, frame_bytes[i]);
		crc = crc ^ CRC_INIT;
		if (bad_crc)
			crc = crc ^ (32'd1 << $urandom_range(0, 31));
		for (int i = 0; i < 4; i++)
			frame_bytes.insert(frame_bytes.size(), crc[8*i +: 8]);
		for (int unsigned i = 0; i < frame_bytes.size() && i < cut_at; i++)
			send_byte(frame_bytes[i]);
	endtask

	// Feed filler bytes until the deframer is back at a frame boundary
	task automatic flush_to_frame_start();
		in_valid <= 1'b0;
		@(posedge clk);
		while (frame_pos != 0) begin
			send_byte(8'hFF);
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Stop offering and let every pending result drain out
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [1:0] idx, input logic [31:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_MAGIC:   cfg_magic = value;
			CFG_VERSION: cfg_version = value;
			CFG_MAX_LEN: cfg_max_len = value[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Reset values: magic 0, version 1; zero length and byte extremes
	task automatic test_reset_defaults();
		tx_idle_pct = 20;
		rx_idle_pct = 20;
		send_frame(32'd0, 32'd1, 32'd0, 0, -1, 1'b0, WHOLE_FRAME);
		send_frame(32'd0, 32'd1, 32'd2, 2, 0, 1'b0, WHOLE_FRAME);
		send_frame(32'd0, 32'd1, 32'd2, 2, 255, 1'b0, WHOLE_FRAME);
		send_frame(32'd0, 32'd1, 32'd3, 3, -1, 1'b1, WHOLE_FRAME);
		wait_idle();
	endtask

	// Bad magic wins over bad version, which wins over a CRC mismatch
	task automatic test_status_priority();
		send_frame(32'h1234_5678, 32'h2, 32'd1, 1, -1, 1'b1, WHOLE_FRAME);
		send_frame(32'h1234_5678, 32'h1, 32'd1, 1, -1, 1'b0, WHOLE_FRAME);
		send_frame(32'h0, 32'h8000_0001, 32'd2, 2, -1, 1'b1, WHOLE_FRAME);
		send_frame(32'h0, 32'h1, 32'd1, 1, -1, 1'b1, WHOLE_FRAME);
		send_frame(32'h0, 32'h1, 32'd1, 1, -1, 1'b0, WHOLE_FRAME);
		wait_idle();
	endtask

	// Length at and over the limit, saturation of the reported length
	task automatic test_length_limit();
		write_cfg(CFG_MAX_LEN, 32'd4);
		send_frame(32'h0, 32'h1, 32'd4, 4, -1, 1'b0, WHOLE_FRAME);
		send_frame(32'h0, 32'h1, 32'd5, 0, -1, 1'b0, HEADER_BYTES);
		send_frame(32'hDEAD_BEEF, 32'h7, 32'd9, 0, -1, 1'b0, HEADER_BYTES);
		send_frame(32'h0, 32'h1, 32'h0100_0000, 0, -1, 1'b0, HEADER_BYTES);
		send_frame(32'h0, 32'h1, 32'hFFFF_FFFF, 0, -1, 1'b0, HEADER_BYTES);
		send_frame(32'h0, 32'h1, 32'd2, 2, -1, 1'b0, WHOLE_FRAME);
		wait_idle();
		write_cfg(CFG_MAX_LEN, 32'd0);
		send_frame(32'h0, 32'h1, 32'd0, 0, -1, 1'b0, WHOLE_FRAME);
		send_frame(32'h0, 32'h1, 32'd1, 0, -1, 1'b0, HEADER_BYTES);
		wait_idle();
		write_cfg(CFG_MAX_LEN, 32'hFFFF_FFFF);
		send_frame(32'h0, 32'h1, 32'h0100_0000, 0, -1, 1'b0, HEADER_BYTES);
		send_frame(32'h0, 32'h1, 32'd3, 3, -1, 1'b0, WHOLE_FRAME);
		wait_idle();
	endtask

	// All-ones and all-zero register words; a write to an unused index is ignored
	task automatic test_register_extremes();
		write_cfg(CFG_MAGIC, 32'hFFFF_FFFF);
		write_cfg(CFG_VERSION, 32'h0);
		write_cfg(CFG_UNUSED, 32'h0000_0005);
		send_frame(32'hFFFF_FFFF, 32'h0, 32'd1, 1, -1, 1'b0, WHOLE_FRAME);
		send_frame(32'h0, 32'h0, 32'd1, 1, -1, 1'b0, WHOLE_FRAME);
		wait_idle();
		write_cfg(CFG_VERSION, 32'hFFFF_FFFF);
		write_cfg(CFG_MAGIC, 32'h0);
		send_frame(32'h0, 32'hFFFF_FFFE, 32'd1, 1, -1, 1'b0, WHOLE_FRAME);
		send_frame(32'h0, 32'hFFFF_FFFF, 32'd2, 2, -1, 1'b0, WHOLE_FRAME);
		wait_idle();
	endtask

	// Receiver holds off long enough for the deframer to stall its input
	task automatic test_output_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 120;
		send_frame(32'h0, 32'hFFFF_FFFF, 32'd60, 60, -1, 1'b0, WHOLE_FRAME);
		send_frame(32'h0, 32'hFFFF_FFFF, 32'd10, 10, -1, 1'b1, WHOLE_FRAME);
		wait_idle();
	endtask

	// Mostly well-formed frames with random content, some faulty, truncated or noise
	task automatic test_random_traffic();
		int unsigned start_bytes;
		int unsigned pick;
		int unsigned len;
		logic [31:0] word;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
				1: begin tx_idle_pct = 30; rx_idle_pct = 30; end
				2: begin tx_idle_pct = 0;  rx_idle_pct = 50; end
				default: begin tx_idle_pct = 50; rx_idle_pct = 0; end
			endcase
			write_cfg(CFG_MAGIC, $urandom());
			write_cfg(CFG_VERSION, $urandom());
			write_cfg(CFG_MAX_LEN, $urandom_range(16, 300));
			start_bytes = bytes_offered;
			while (bytes_offered < start_bytes + 50) begin
				pick = $urandom_range(0, 99);
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, cfg_max_len)
					: $urandom_range(0, 24);
				if (pick < 55) begin
					send_frame(cfg_magic, cfg_version, len, len, -1, 1'b0, WHOLE_FRAME);
				end else if (pick < 63) begin
					word = cfg_magic ^ (32'd1 << $urandom_range(0, 31));
					send_frame(word, cfg_version, len, len, -1, 1'($urandom_range(0, 1)),
						WHOLE_FRAME);
				end else if (pick < 71) begin
					word = cfg_version ^ (32'd1 << $urandom_range(0, 31));
					send_frame(cfg_magic, word, len, len, -1, 1'($urandom_range(0, 1)),
						WHOLE_FRAME);
				end else if (pick < 79) begin
					send_frame(cfg_magic, cfg_version, len, len, -1, 1'b1, WHOLE_FRAME);
				end else if (pick < 85) begin
					word = $urandom_range(0, 1) ? (cfg_max_len + 1 + $urandom_range(0, 500))
						: $urandom();
					if (word <= {8'd0, cfg_max_len})
						word = 32'hFFFF_FFFF;
					send_frame(cfg_magic, cfg_version, word, 0, -1, 1'b0, HEADER_BYTES);
				end else if (pick < 92) begin
					send_frame(cfg_magic, cfg_version, len, len, -1, 1'b0,
						$urandom_range(1, HEADER_BYTES + CRC_BYTES + len - 1));
					flush_to_frame_start();
				end else begin
					repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
					flush_to_frame_start();
				end
			end
			wait_idle();
		end
	endtask

	// Watchdog
	initial begin
		#8_000_000;
		$display("frame_deframer_crc32_check regression: fail");
		$finish;
	end

	initial begin
		cfg_magic   = 32'd0;
		cfg_version = 32'd1;
		cfg_max_len = 24'd65536;
		frame_restart();
		foreach (status_count[i])
			status_count[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_status_priority();
		test_length_limit();
		test_register_extremes();
		test_output_backpressure();
		test_random_traffic();
		wait_idle();

		$display("Covered %0d bytes taken, %0d payload bytes out, %0d cycles of input stall",
			bytes_taken, payloads_seen, input_stalls);
		$display("Frame ends: good %0d, bad magic %0d, bad version %0d, over limit %0d, crc %0d",
			status_count[ST_GOOD], status_count[ST_BAD_MAGIC], status_count[ST_BAD_VERSION],
			status_count[ST_LEN_OVER], status_count[ST_CRC_BAD]);
		if (mismatches == 0)
			$display("frame_deframer_crc32_check regression: pass");
		else
			$display("frame_deframer_crc32_check regression: fail");
		$finish;
	end

endmodule
